### sv/fat12_pkg.sv
`default_nettype none
package fat12_pkg;

  // Allocation table size in bytes; must be a power of two.
  localparam int TABLE_BYTES = 1024;
  localparam int TBL_AW      = $clog2(TABLE_BYTES);
  localparam int AT_W        = 14;

  localparam logic [11:0] ENTRY_MASK = 12'h0FFF;
  localparam logic [11:0] CHAIN_END  = 12'h0FF8;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  localparam logic [1:0] STAT_LOADED = 2'd0;
  localparam logic [1:0] STAT_EMIT   = 2'd1;
  localparam logic [1:0] STAT_BAD    = 2'd2;
  localparam logic [1:0] STAT_NONE   = 2'd3;

  localparam logic [1:0] CFG_DATA_START = 2'd0;
  localparam logic [1:0] CFG_SPC        = 2'd1;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [7:0]        data;
  } fat12_wr_t;

  // Byte offset of a cluster's packed entry: c * 3 / 2.
  function automatic logic [AT_W-1:0] at_of(input logic [11:0] c);
    return AT_W'(c) + AT_W'(c[11:1]);
  endfunction

  function automatic logic cluster_ok(input logic [11:0] c);
    logic [AT_W-1:0] at;
    at = at_of(c);
    return (c >= 12'd2) && (c < CHAIN_END) && ((int'(at) + 1) < TABLE_BYTES);
  endfunction

  // Even clusters take the low 12 bits of the word, odd ones the high 12.
  function automatic logic [11:0] entry_of(input logic odd, input logic [15:0] word);
    return odd ? word[15:4] : (word[11:0] & ENTRY_MASK);
  endfunction

endpackage
`default_nettype wire

### sv/fat12_table.sv
`default_nettype none
module fat12_table import fat12_pkg::*; (
  input  logic             clk_i,
  input  fat12_wr_t        wr_i,
  input  logic             rd_en_i,
  input  logic [TBL_AW-1:0] rd_at_i,
  output logic [15:0]      rd_word_o
);

  localparam int HALF_AW    = TBL_AW - 1;
  localparam int HALF_DEPTH = TABLE_BYTES / 2;

  // Even bytes in one bank, odd bytes in the other: any two adjacent
  // bytes come out of a single read.
  logic [7:0] even_mem [HALF_DEPTH];
  logic [7:0] odd_mem  [HALF_DEPTH];

  logic [HALF_AW-1:0] base;
  logic [HALF_AW-1:0] even_idx;
  logic [7:0]         even_q;
  logic [7:0]         odd_q;
  logic               swap_q;

  assign base     = rd_at_i[TBL_AW-1:1];
  assign even_idx = base + HALF_AW'(rd_at_i[0]);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.addr[0]) begin
      even_mem[wr_i.addr[TBL_AW-1:1]] <= wr_i.data;
    end
    if (rd_en_i) begin
      even_q <= even_mem[even_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.addr[0]) begin
      odd_mem[wr_i.addr[TBL_AW-1:1]] <= wr_i.data;
    end
    if (rd_en_i) begin
      odd_q  <= odd_mem[base];
      swap_q <= rd_at_i[0];
    end
  end

  assign rd_word_o = swap_q ? {even_q, odd_q} : {odd_q, even_q};

endmodule
`default_nettype wire

### sv/fat12_cluster_chain_walker_top.sv
`default_nettype none
// FAT12 cluster chain walker. Load items (kind 0) write one byte of the
// allocation table and finish without a table read. A start item (kind 1)
// with a valid first cluster, and an advance item (kind 2) on an active chain
// whose next cluster is valid, go through a lookup: the item's cycle issues a
// synchronous read of the two table bytes that hold the cluster's packed
// entry, and the next cycle decodes the entry and emits the result. Every
// other item (a bad first cluster, a bad next cluster, an advance with no
// active chain, the unused kind three) finishes without a table read. busy
// is high during the decode cycle only. Every accepted item
// gives exactly one result, shown for one cycle with result_valid_o high;
// there is no back-pressure, so the receiver must take each result when it
// appears. sector_lba_o = data_start_lba + (cluster - 2) * sectors_per_cluster,
// wrapped to 20 bits. The table store is not cleared at reset: walking a
// chain through bytes that were never loaded gives undefined fields.
// Configuration writes (index 0 data start sector, index 1 sectors per
// cluster) are always ready and must only be issued while no item is in
// flight.
module fat12_cluster_chain_walker_top import fat12_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  table_address_i,
  input  logic [7:0]  table_byte_i,
  input  logic [11:0] first_cluster_i,
  output logic        result_valid_o,
  output logic [19:0] sector_lba_o,
  output logic [11:0] cluster_o,
  output logic [11:0] chain_index_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic {ST_IDLE, ST_LOOKUP} state_e;

  state_e      state_q;
  logic [15:0] data_start_q;
  logic [7:0]  spc_q;

  // Chain state.
  logic        active_q;
  logic [11:0] cur_q;
  logic [11:0] pos_q;
  logic [15:0] word_q;     // cached table word of the current cluster
  logic [AT_W-1:0] cur_at_q;

  // Pending emit.
  logic [11:0] pend_c_q;
  logic [11:0] pend_pos_q;
  logic [19:0] prod_q;

  logic        accept;
  logic        is_load, is_start, is_adv;
  logic        addr_ok;
  logic [AT_W-1:0] addr_ext;
  logic        ok_first;
  logic [11:0] next_c;
  logic        ok_next;
  logic [11:0] pos_next;
  logic [11:0] sel_c;
  logic [19:0] prod_d;
  logic        rd_en;
  logic [15:0] rd_word;
  logic [11:0] lk_entry;
  logic        lk_last;
  fat12_wr_t   wr;

  assign busy        = (state_q == ST_LOOKUP);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign is_load  = (kind_i == KIND_LOAD);
  assign is_start = (kind_i == KIND_START);
  assign is_adv   = (kind_i == KIND_ADVANCE);

  assign addr_ok  = (int'(table_address_i) < TABLE_BYTES);
  assign addr_ext = AT_W'(table_address_i);

  assign ok_first = cluster_ok(first_cluster_i);
  // The next cluster comes from the cached word; no table read needed.
  assign next_c   = entry_of(cur_q[0], word_q);
  assign ok_next  = cluster_ok(next_c);
  assign pos_next = pos_q + 12'd1;

  assign sel_c  = is_start ? first_cluster_i : next_c;
  assign prod_d = 20'(12'(sel_c - 12'd2)) * 20'(spc_q);

  assign rd_en = accept && ((is_start && ok_first) || (is_adv && active_q && ok_next));

  assign wr.en   = accept && is_load && addr_ok;
  assign wr.addr = TBL_AW'(table_address_i);
  assign wr.data = table_byte_i;

  fat12_table u_table (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_en_i  (rd_en),
    .rd_at_i  (TBL_AW'(at_of(sel_c))),
    .rd_word_o(rd_word)
  );

  assign lk_entry = entry_of(pend_c_q[0], rd_word);
  assign lk_last  = (lk_entry >= CHAIN_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= 16'd33;
      spc_q        <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DATA_START: data_start_q <= cfg_data_i;
        CFG_SPC:        spc_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_q       <= 1'b0;
      cur_q          <= '0;
      pos_q          <= '0;
      word_q         <= '0;
      cur_at_q       <= '0;
      pend_c_q       <= '0;
      pend_pos_q     <= '0;
      prod_q         <= '0;
      result_valid_o <= 1'b0;
      sector_lba_o   <= '0;
      cluster_o      <= '0;
      chain_index_o  <= '0;
      last_o         <= 1'b0;
      status_o       <= STAT_LOADED;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // Default result: no active chain, all fields zero.
            sector_lba_o  <= '0;
            cluster_o     <= '0;
            chain_index_o <= '0;
            last_o        <= 1'b0;
            status_o      <= STAT_NONE;
            priority if (is_load) begin
              result_valid_o <= 1'b1;
              status_o       <= STAT_LOADED;
              // Forward the new byte into the cached word of the current cluster.
              if (addr_ok && addr_ext == cur_at_q) begin
                word_q[7:0] <= table_byte_i;
              end
              if (addr_ok && addr_ext == cur_at_q + AT_W'(1)) begin
                word_q[15:8] <= table_byte_i;
              end
            end else if (is_start) begin
              if (ok_first) begin
                pend_c_q   <= first_cluster_i;
                pend_pos_q <= '0;
                prod_q     <= prod_d;
                state_q    <= ST_LOOKUP;
              end else begin
                result_valid_o <= 1'b1;
                cluster_o      <= first_cluster_i;
                status_o       <= STAT_BAD;
                active_q       <= 1'b0;
              end
            end else if (is_adv && active_q) begin
              if (ok_next) begin
                pend_c_q   <= next_c;
                pend_pos_q <= pos_next;
                prod_q     <= prod_d;
                state_q    <= ST_LOOKUP;
              end else begin
                result_valid_o <= 1'b1;
                cluster_o      <= next_c;
                chain_index_o  <= pos_next;
                status_o       <= STAT_BAD;
                active_q       <= 1'b0;
              end
            end else begin
              result_valid_o <= 1'b1;
            end
          end
        end
        ST_LOOKUP: begin
          // Emit the pending cluster and cache its word for the next advance.
          result_valid_o <= 1'b1;
          sector_lba_o   <= 20'(data_start_q) + prod_q;
          cluster_o      <= pend_c_q;
          chain_index_o  <= pend_pos_q;
          last_o         <= lk_last;
          status_o       <= STAT_EMIT;
          cur_q          <= pend_c_q;
          pos_q          <= pend_pos_q;
          active_q       <= !lk_last;
          word_q         <= rd_word;
          cur_at_q       <= at_of(pend_c_q);
          state_q        <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // No result appears while the decode cycle is in progress.
  a_no_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result strobe during lookup");

  // A lookup always finishes in the following cycle.
  a_lookup_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (state_q == ST_IDLE))
    else $error("lookup did not finish");

  // An emitted cluster leaves the chain active exactly when it is not last.
  a_emit_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == STAT_EMIT) |-> (active_q == !last_o))
    else $error("chain activity disagrees with last mark");

  // A bad cluster result always drops the chain.
  a_bad_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == STAT_BAD) |-> !active_q)
    else $error("chain still active after bad cluster");

endmodule
`default_nettype wire
